[src/sacl_pkg.sv]
// Shared types and constants of the set-associative LRU cache unit.
package sacl_pkg;

    localparam int MAX_SET_BITS_DEF = 8;
    localparam int MAX_WAYS_DEF     = 8;

    localparam logic [3:0] SET_BITS_RST   = 4'd4;
    localparam logic [5:0] OFFSET_BITS_RST = 6'd4;
    localparam logic [3:0] WAYS_RST       = 4'd1;

    typedef enum logic [1:0]
    {
        OP_LOAD   = 2'd0,
        OP_STORE  = 2'd1,
        OP_MODIFY = 2'd2,
        OP_FETCH  = 2'd3
    } opcode_t;

    typedef enum logic [1:0]
    {
        OUT_HIT   = 2'd0,
        OUT_FILL  = 2'd1,
        OUT_EVICT = 2'd2
    } outcome_t;

    typedef enum logic [1:0]
    {
        REG_SET_BITS    = 2'd0,
        REG_OFFSET_BITS = 2'd1,
        REG_WAYS        = 2'd2
    } reg_index_t;

    typedef struct packed
    {
        logic [3:0] set_index_bits;
        logic [5:0] block_offset_bits;
        logic [3:0] ways_in_use;
    } cfg_t;

endpackage

[src/set_assoc_lru_cache_sim_unit.sv]
// Top level of the set-associative LRU cache unit: configuration registers and wiring.
//
// After reset the unit clears the valid bits of the set memory, one set a cycle, and
// accepts no transaction until that pass ends; configuration writes are taken
// throughout. A load or store then reads its set into registers as it is popped
// from the queue, and in ST_LOOK compares the ways, chooses the victim and writes
// back; no new access is popped until the sequencer is idle again. A modify gives
// its second result, always a hit, in the cycle after the first is taken, and an
// instruction fetch only advances the access clock in the front end, unqueued.
module set_assoc_lru_cache_sim_unit #(
    parameter int MAX_SET_BITS = sacl_pkg::MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = sacl_pkg::MAX_WAYS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [63:0]   s_tdata,   // address
    input  logic [1:0]    s_tuser,   // opcode
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [103:0]  m_tdata,   // outcome, hit_total, miss_total, eviction_total
    output logic          m_tlast
);
    import sacl_pkg::*;

    localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int EW    = SET_W + 97;

    cfg_t          cfg_reg;
    logic          clearing;
    logic          q_full;
    logic          q_empty;
    logic          push;
    logic          pop;
    logic [EW-1:0] push_data;
    logic [EW-1:0] head;
    reg_index_t    rd_index;

    assign pready   = 1'b1;
    assign rd_index = reg_index_t'(paddr[3:2]);

    always_comb
    begin
        prdata = 32'd0;
        unique case (rd_index)
            REG_SET_BITS:    prdata = 32'(cfg_reg.set_index_bits);
            REG_OFFSET_BITS: prdata = 32'(cfg_reg.block_offset_bits);
            REG_WAYS:        prdata = 32'(cfg_reg.ways_in_use);
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.set_index_bits    <= SET_BITS_RST;
            cfg_reg.block_offset_bits <= OFFSET_BITS_RST;
            cfg_reg.ways_in_use       <= WAYS_RST;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (rd_index)
                REG_SET_BITS:    cfg_reg.set_index_bits    <= pwdata[3:0];
                REG_OFFSET_BITS: cfg_reg.block_offset_bits <= pwdata[5:0];
                REG_WAYS:        cfg_reg.ways_in_use       <= pwdata[3:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    sacl_front #(.MAX_SET_BITS(MAX_SET_BITS), .SET_W(SET_W)) u_front (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg), .clearing(clearing),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .q_full(q_full), .push(push), .push_data(push_data)
    );

    sacl_queue #(.W(EW)) u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data),
        .pop(pop), .head(head), .empty(q_empty), .full(q_full)
    );

    sacl_back #(.MAX_SET_BITS(MAX_SET_BITS), .MAX_WAYS(MAX_WAYS), .SET_W(SET_W)) u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg), .clearing(clearing),
        .head(head), .q_empty(q_empty), .pop(pop),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );
endmodule

[src/sacl_front.sv]
// Front end: accepts accesses, advances the access clock and splits the address.
module sacl_front #(
    parameter int MAX_SET_BITS = sacl_pkg::MAX_SET_BITS_DEF,
    parameter int SET_W        = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sacl_pkg::cfg_t      cfg,
    input  logic                clearing,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [63:0]         s_tdata,
    input  logic [1:0]          s_tuser,
    input  logic                q_full,
    output logic                push,
    output logic [SET_W+96:0]   push_data
);
    import sacl_pkg::*;

    logic [31:0] clock_reg;
    logic [31:0] clock_next;
    logic [3:0]  s_eff;
    logic [6:0]  shift_sum;
    logic [63:0] set_mask;
    logic [63:0] set_wide;
    logic [63:0] tag;
    logic        accept;

    assign s_tready   = !q_full && !clearing;
    assign accept     = s_tvalid && s_tready;
    assign clock_next = clock_reg + 32'd1;

    always_comb
    begin
        if (32'(cfg.set_index_bits) > MAX_SET_BITS)
            s_eff = 4'(MAX_SET_BITS);
        else
            s_eff = cfg.set_index_bits;
        shift_sum = 7'(s_eff) + 7'(cfg.block_offset_bits);
        set_mask  = (64'd1 << s_eff) - 64'd1;
        set_wide  = (s_tdata >> cfg.block_offset_bits) & set_mask;
        if (shift_sum >= 7'd64)
            tag = 64'd0;
        else
            tag = s_tdata >> shift_sum;
    end

    assign push      = accept && (opcode_t'(s_tuser) != OP_FETCH);
    assign push_data = {(opcode_t'(s_tuser) == OP_MODIFY), SET_W'(set_wide), tag, clock_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clock_reg <= 32'd0;
        else if (accept)
            clock_reg <= clock_next;
    end
endmodule

[src/sacl_queue.sv]
// Two-entry queue between the front end and the back end.
module sacl_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    input  logic         pop,
    output logic [W-1:0] head,
    output logic         empty,
    output logic         full
);
    logic [W-1:0] slot_reg [2];
    logic [1:0]   count_reg;
    logic [1:0]   count_next;

    assign empty = (count_reg == 2'd0);
    assign full  = (count_reg == 2'd2);
    assign head  = slot_reg[0];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            slot_reg[0] <= slot_reg[1];
            if (push && count_reg == 2'd1)
                slot_reg[0] <= push_data;
            if (push && count_reg == 2'd2)
                slot_reg[1] <= push_data;
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
                slot_reg[0] <= push_data;
            else
                slot_reg[1] <= push_data;
        end
    end
endmodule

[src/sacl_back.sv]
// Back end: set memory, lookup and replacement sequencer, totals and output register.
module sacl_back #(
    parameter int MAX_SET_BITS = sacl_pkg::MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = sacl_pkg::MAX_WAYS_DEF,
    parameter int SET_W        = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sacl_pkg::cfg_t      cfg,
    output logic                clearing,
    input  logic [SET_W+96:0]   head,
    input  logic                q_empty,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [103:0]        m_tdata,
    output logic                m_tlast
);
    import sacl_pkg::*;

    localparam int ROWS  = 1 << MAX_SET_BITS;
    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

    typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_LOOK, ST_SECOND} state_t;

    logic [MAX_WAYS-1:0] valid_mem [ROWS];
    logic [63:0]         tag_mem   [ROWS][MAX_WAYS];
    logic [31:0]         rec_mem   [ROWS][MAX_WAYS];

    state_t              state_reg;
    logic [SET_W:0]      clr_reg;
    logic [SET_W-1:0]    set_reg;
    logic [63:0]         tag_reg;
    logic [31:0]         stamp_reg;
    logic                mod_reg;
    logic [MAX_WAYS-1:0] rd_valid_reg;
    logic [63:0]         rd_tag_reg [MAX_WAYS];
    logic [31:0]         rd_rec_reg [MAX_WAYS];
    logic                out_valid_reg;
    logic [1:0]          outcome_reg;
    logic                last_reg;
    logic [31:0]         hits_reg;
    logic [31:0]         misses_reg;
    logic [31:0]         evicts_reg;

    logic [4:0]          ways;
    logic                hit_found;
    logic                empty_found;
    logic                old_found;
    logic [WAY_W-1:0]    hit_way;
    logic [WAY_W-1:0]    empty_way;
    logic [WAY_W-1:0]    old_way;
    logic [31:0]         old_age;
    logic [31:0]         age;
    logic                out_free;
    logic                wr_en;
    logic                wr_fill;
    logic [WAY_W-1:0]    wr_way;

    assign clearing = (state_reg == ST_CLEAR);
    assign out_free = !out_valid_reg || m_tready;
    assign pop      = (state_reg == ST_IDLE) && !q_empty && out_free;
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {6'd0, evicts_reg, misses_reg, hits_reg, outcome_reg};

    always_comb
    begin
        if (cfg.ways_in_use == 4'd0)
            ways = 5'd1;
        else if (32'(cfg.ways_in_use) > MAX_WAYS)
            ways = 5'(MAX_WAYS);
        else
            ways = {1'b0, cfg.ways_in_use};
        hit_found   = 1'b0;
        empty_found = 1'b0;
        old_found   = 1'b0;
        hit_way     = '0;
        empty_way   = '0;
        old_way     = '0;
        old_age     = 32'd0;
        age         = 32'd0;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (5'(w) < ways)
            begin
                age = stamp_reg - rd_rec_reg[w];
                if (rd_valid_reg[w])
                begin
                    if (!hit_found && rd_tag_reg[w] == tag_reg)
                    begin
                        hit_found = 1'b1;
                        hit_way   = WAY_W'(w);
                    end
                    if (!old_found || age > old_age)
                    begin
                        old_found = 1'b1;
                        old_way   = WAY_W'(w);
                        old_age   = age;
                    end
                end
                else if (!empty_found)
                begin
                    empty_found = 1'b1;
                    empty_way   = WAY_W'(w);
                end
            end
        end
        wr_en   = (state_reg == ST_LOOK);
        wr_fill = !hit_found && empty_found;
        if (hit_found)
            wr_way = hit_way;
        else if (empty_found)
            wr_way = empty_way;
        else
            wr_way = old_way;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
            valid_mem[clr_reg[SET_W-1:0]] <= '0;
        else if (wr_en && wr_fill)
            valid_mem[set_reg][wr_way] <= 1'b1;
        if (wr_en)
        begin
            rec_mem[set_reg][wr_way] <= stamp_reg;
            if (!hit_found)
                tag_mem[set_reg][wr_way] <= tag_reg;
        end
        if (pop)
        begin
            set_reg      <= head[SET_W+95:96];
            tag_reg      <= head[95:32];
            stamp_reg    <= head[31:0];
            mod_reg      <= head[SET_W+96];
            rd_valid_reg <= valid_mem[head[SET_W+95:96]];
            for (int w = 0; w < MAX_WAYS; w++)
            begin
                rd_tag_reg[w] <= tag_mem[head[SET_W+95:96]][w];
                rd_rec_reg[w] <= rec_mem[head[SET_W+95:96]][w];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            outcome_reg   <= OUT_HIT;
            last_reg      <= 1'b0;
            hits_reg      <= 32'd0;
            misses_reg    <= 32'd0;
            evicts_reg    <= 32'd0;
        end
        else
        begin
            if (m_tready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + (SET_W+1)'(1);
                    if (clr_reg == (SET_W+1)'(ROWS - 1))
                        state_reg <= ST_IDLE;
                end
                ST_IDLE:
                begin
                    if (pop)
                        state_reg <= ST_LOOK;
                end
                ST_LOOK:
                begin
                    out_valid_reg <= 1'b1;
                    last_reg      <= !mod_reg;
                    if (hit_found)
                    begin
                        outcome_reg <= OUT_HIT;
                        if (hits_reg != 32'hFFFF_FFFF)
                            hits_reg <= hits_reg + 32'd1;
                    end
                    else
                    begin
                        if (misses_reg != 32'hFFFF_FFFF)
                            misses_reg <= misses_reg + 32'd1;
                        if (empty_found)
                            outcome_reg <= OUT_FILL;
                        else
                        begin
                            outcome_reg <= OUT_EVICT;
                            if (evicts_reg != 32'hFFFF_FFFF)
                                evicts_reg <= evicts_reg + 32'd1;
                        end
                    end
                    state_reg <= mod_reg ? ST_SECOND : ST_IDLE;
                end
                ST_SECOND:
                begin
                    if (m_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        last_reg      <= 1'b1;
                        outcome_reg   <= OUT_HIT;
                        if (hits_reg != 32'hFFFF_FFFF)
                            hits_reg <= hits_reg + 32'd1;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

[src/sacl_checker.sv]
// Port-level checker of the cache unit and its bind to the top level.
module sacl_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         pready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [103:0] m_tdata,
    input logic         m_tlast
);
    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_outcome_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[1:0] != 2'd3)
        else $error("outcome code out of range");

    a_second_is_hit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tlast && m_tdata[1:0] == 2'd0)
        else $error("second half of a modify is not a hit");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");
endmodule

bind set_assoc_lru_cache_sim_unit sacl_checker u_sacl_checker (
    .clk(clk), .rst_n(rst_n), .pready(pready), .m_tvalid(m_tvalid),
    .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
